### src/ssa_pkg.sv
// Shared types and constants of the SiLU and sigmoid activation unit.
package ssa_pkg;

	localparam logic [63:0] QONE = 64'h4000_0000_0000_0000;
	localparam logic [63:0] LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;
	localparam int N_TERMS = 22;
	localparam int N_DIV = 63;
	localparam int K_W = 7;
	localparam int K_ZERO = 63;

	localparam logic [1:0] ACT_SILU = 2'd0;
	localparam logic [1:0] ACT_SILU_GRAD = 2'd1;
	localparam logic [1:0] ACT_SIGMOID = 2'd2;
	localparam logic [1:0] ACT_SIGMOID_GRAD = 2'd3;

	typedef struct packed {
		logic [1:0] act;
		logic xneg;
		logic gneg;
		logic neg;
		logic big;
		logic last;
		logic [31:0] xm;
		logic [31:0] gm;
		logic [K_W-1:0] k;
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] t;
	} item_t;

endpackage

### src/ssa_mul64.sv
// Two-stage 64 by 64 bit unsigned multiplier built from four 32 bit partial products.
module ssa_mul64 (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input ssa_pkg::item_t in_item,
	input logic [63:0] a,
	input logic [63:0] b,
	output logic out_v,
	output ssa_pkg::item_t out_item,
	output logic [127:0] prod
);
	import ssa_pkg::*;

	logic [63:0] pp_s1 [4];
	logic v_s1;
	logic v_s2;
	item_t item_s1;
	item_t item_s2;
	logic [127:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= 64'(a[31:0]) * 64'(b[31:0]);
			pp_s1[1] <= 64'(a[31:0]) * 64'(b[63:32]);
			pp_s1[2] <= 64'(a[63:32]) * 64'(b[31:0]);
			pp_s1[3] <= 64'(a[63:32]) * 64'(b[63:32]);
			item_s1 <= in_item;
			prod_s2 <= {64'd0, pp_s1[0]} + {32'd0, pp_s1[1], 32'd0}
				+ {32'd0, pp_s1[2], 32'd0} + {pp_s1[3], 64'd0};
			item_s2 <= item_s1;
		end
	end

	assign out_v = v_s2;
	assign out_item = item_s2;
	assign prod = prod_s2;

endmodule

### src/ssa_horner_cell.sv
// One Horner step of the exponential series: e = 1 - (r * e) / DIVISOR.
module ssa_horner_cell #(
	parameter int DIVISOR = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input ssa_pkg::item_t in_item,
	input logic [63:0] in_e,
	output logic out_v,
	output ssa_pkg::item_t out_item,
	output logic [63:0] out_e
);
	import ssa_pkg::*;

	localparam logic [63:0] DIV64 = 64'(DIVISOR);
	localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / DIV64;

	logic v1;
	logic v2;
	item_t item1;
	item_t item2;
	logic [127:0] prod1;
	logic [127:0] prod2;
	logic [63:0] p;
	logic [63:0] p_s3;
	logic [63:0] p_s4;
	logic [63:0] q0;
	logic [63:0] qi;
	logic [63:0] rem;
	logic [63:0] q;
	logic v_s5;
	item_t item_s5;
	logic [63:0] e_s5;

	ssa_mul64 u_mul_re (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(in_v), .in_item(in_item), .a(in_item.r), .b(in_e),
		.out_v(v1), .out_item(item1), .prod(prod1)
	);

	assign p = {2'd0, prod1[123:62]};

	ssa_mul64 u_mul_recip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(v1), .in_item(item1), .a(p), .b(RECIP),
		.out_v(v2), .out_item(item2), .prod(prod2)
	);

	assign q0 = prod2[127:64];
	assign qi = q0 * DIV64;
	assign rem = p_s4 - qi;
	assign q = q0 + 64'(rem >= DIV64);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= p;
			p_s4 <= p_s3;
			item_s5 <= item2;
			e_s5 <= QONE - q;
		end
	end

	assign out_v = v_s5;
	assign out_item = item_s5;
	assign out_e = e_s5;

endmodule

### src/ssa_div_cell.sv
// One restoring division step for the sigmoid and its complement over a shared divisor.
module ssa_div_cell #(
	parameter bit SHIFT = 1'b1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input ssa_pkg::item_t in_item,
	input logic [63:0] in_den,
	input logic [63:0] in_rh,
	input logic [63:0] in_rl,
	input logic [62:0] in_qh,
	input logic [62:0] in_ql,
	output logic out_v,
	output ssa_pkg::item_t out_item,
	output logic [63:0] out_den,
	output logic [63:0] out_rh,
	output logic [63:0] out_rl,
	output logic [62:0] out_qh,
	output logic [62:0] out_ql
);
	import ssa_pkg::*;

	logic [63:0] rh;
	logic [63:0] rl;
	logic [62:0] qh;
	logic [62:0] ql;
	logic bh;
	logic bl;
	logic v_s1;
	item_t item_s1;
	logic [63:0] den_s1;
	logic [63:0] rh_s1;
	logic [63:0] rl_s1;
	logic [62:0] qh_s1;
	logic [62:0] ql_s1;

	assign rh = SHIFT ? {in_rh[62:0], 1'b0} : in_rh;
	assign rl = SHIFT ? {in_rl[62:0], 1'b0} : in_rl;
	assign qh = SHIFT ? {in_qh[61:0], 1'b0} : in_qh;
	assign ql = SHIFT ? {in_ql[61:0], 1'b0} : in_ql;
	assign bh = rh >= in_den;
	assign bl = rl >= in_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			den_s1 <= in_den;
			rh_s1 <= bh ? rh - in_den : rh;
			rl_s1 <= bl ? rl - in_den : rl;
			qh_s1 <= {qh[62:1], bh};
			ql_s1 <= {ql[62:1], bl};
		end
	end

	assign out_v = v_s1;
	assign out_item = item_s1;
	assign out_den = den_s1;
	assign out_rh = rh_s1;
	assign out_rl = rl_s1;
	assign out_qh = qh_s1;
	assign out_ql = ql_s1;

endmodule

### src/sigmoid_silu_activation_unit.sv
// Top level of the pipelined SiLU and sigmoid activation unit with gradients.
// The input channel carries one word per element: action, x_value, grad_value and
// last_in, taken at an edge where valid is high and stall is low. The result channel
// returns result_value, saturated and last_out under result_valid and result_stall.
// Every element yields exactly one result word, in order.
// The datapath is a chain of cells: seven range reduction cells, twenty-two Horner
// cells of five stages each for the exponential, sixty-three division cells for the
// sigmoid and its complement, then the multiplier stages for the final product.
// One word is accepted in every cycle while the result side keeps up.
// An output register and a skid register sit at the end of the chain. When the
// receiver stalls, one more result moves into the skid register, after which stall
// rises and the whole chain holds its contents until the skid register drains.
// Reset clears the valid bits of every stage and both output registers; no
// element state survives reset.
module sigmoid_silu_activation_unit #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] action,
	input logic signed [31:0] x_value,
	input logic signed [31:0] grad_value,
	input logic last_in,
	output logic result_valid,
	input logic result_stall,
	output logic signed [31:0] result_value,
	output logic saturated,
	output logic last_out
);
	import ssa_pkg::*;

	localparam logic [31:0] LIMIT = 32'd80 << FRAC_BITS;
	localparam int A56_SHIFT = 56 - FRAC_BITS;
	localparam logic [31:0] ONE_FIX = 32'd1 << FRAC_BITS;
	localparam logic [127:0] HALF_ULP = 128'd1 << 61;

	logic en;
	logic skid_v_q;
	logic out_v_q;
	logic take;

	assign en = !skid_v_q;
	assign stall = skid_v_q;

	logic [31:0] xr;
	logic [31:0] gr;
	logic [31:0] xm;
	logic [31:0] gm;
	item_t in_item;

	assign xr = x_value;
	assign gr = grad_value;
	assign xm = xr[31] ? 32'd0 - xr : xr;
	assign gm = gr[31] ? 32'd0 - gr : gr;

	always_comb begin
		in_item = '0;
		in_item.act = action;
		in_item.xneg = xr[31];
		in_item.gneg = gr[31];
		in_item.big = xm > LIMIT;
		in_item.last = last_in;
		in_item.xm = xm;
		in_item.gm = gm;
	end

	logic kd_v [K_W+1];
	item_t kd_item [K_W+1];
	logic [63:0] kd_rem [K_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kd_v[0] <= 1'b0;
		end else if (en) begin
			kd_v[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kd_item[0] <= in_item;
			kd_rem[0] <= in_item.big ? 64'd0 : {32'd0, xm} << A56_SHIFT;
		end
	end

	for (genvar j = 0; j < K_W; j++) begin : g_kdiv
		localparam logic [63:0] STEP = LN2_Q56 << (K_W - 1 - j);
		item_t nxt;
		logic ge;

		assign ge = kd_rem[j] >= STEP;

		always_comb begin
			nxt = kd_item[j];
			nxt.k[K_W-1-j] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				kd_v[j+1] <= 1'b0;
			end else if (en) begin
				kd_v[j+1] <= kd_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				kd_item[j+1] <= nxt;
				kd_rem[j+1] <= ge ? kd_rem[j] - STEP : kd_rem[j];
			end
		end
	end

	logic h_v [N_TERMS+1];
	item_t h_item [N_TERMS+1];
	logic [63:0] h_e [N_TERMS+1];

	always_comb begin
		h_item[0] = kd_item[K_W];
		h_item[0].r = {kd_rem[K_W][57:0], 6'd0};
	end
	assign h_v[0] = kd_v[K_W];
	assign h_e[0] = QONE;

	for (genvar j = 0; j < N_TERMS; j++) begin : g_horner
		ssa_horner_cell #(.DIVISOR(N_TERMS - j)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_v(h_v[j]), .in_item(h_item[j]), .in_e(h_e[j]),
			.out_v(h_v[j+1]), .out_item(h_item[j+1]), .out_e(h_e[j+1])
		);
	end

	logic [63:0] e_sh;
	assign e_sh = (h_item[N_TERMS].k >= K_W'(K_ZERO)) ? 64'd0
		: h_e[N_TERMS] >> h_item[N_TERMS].k;

	logic d_v [N_DIV+1];
	item_t d_item [N_DIV+1];
	logic [63:0] d_den [N_DIV+1];
	logic [63:0] d_rh [N_DIV+1];
	logic [63:0] d_rl [N_DIV+1];
	logic [62:0] d_qh [N_DIV+1];
	logic [62:0] d_ql [N_DIV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_v[0] <= 1'b0;
		end else if (en) begin
			d_v[0] <= h_v[N_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_item[0] <= h_item[N_TERMS];
			d_den[0] <= QONE + e_sh;
			d_rh[0] <= QONE;
			d_rl[0] <= e_sh;
			d_qh[0] <= '0;
			d_ql[0] <= '0;
		end
	end

	for (genvar j = 0; j < N_DIV; j++) begin : g_div
		ssa_div_cell #(.SHIFT(j != 0)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_v(d_v[j]), .in_item(d_item[j]), .in_den(d_den[j]),
			.in_rh(d_rh[j]), .in_rl(d_rl[j]), .in_qh(d_qh[j]), .in_ql(d_ql[j]),
			.out_v(d_v[j+1]), .out_item(d_item[j+1]), .out_den(d_den[j+1]),
			.out_rh(d_rh[j+1]), .out_rl(d_rl[j+1]), .out_qh(d_qh[j+1]), .out_ql(d_ql[j+1])
		);
	end

	logic [63:0] s_val;
	logic [63:0] oms_val;
	item_t mt_in;
	logic mt_v;
	item_t mt_item;
	logic [127:0] mt_prod;

	assign s_val = {1'b0, d_item[N_DIV].xneg ? d_ql[N_DIV] : d_qh[N_DIV]};
	assign oms_val = {1'b0, d_item[N_DIV].xneg ? d_qh[N_DIV] : d_ql[N_DIV]};

	always_comb begin
		mt_in = d_item[N_DIV];
		mt_in.s = s_val;
	end

	ssa_mul64 u_mul_t (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(d_v[N_DIV]), .in_item(mt_in), .a(s_val), .b(oms_val),
		.out_v(mt_v), .out_item(mt_item), .prod(mt_prod)
	);

	logic [63:0] t_val;
	item_t mu_in;
	logic mu_v;
	item_t mu_item;
	logic [127:0] mu_prod;

	assign t_val = {2'd0, mt_prod[123:62]};

	always_comb begin
		mu_in = mt_item;
		mu_in.t = t_val;
	end

	ssa_mul64 u_mul_u (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(mt_v), .in_item(mu_in), .a({32'd0, mt_item.xm}), .b(t_val),
		.out_v(mu_v), .out_item(mu_item), .prod(mu_prod)
	);

	logic [63:0] u_val;
	logic [63:0] dm;
	logic dneg;
	logic [31:0] fa;
	logic [63:0] fb;
	logic fneg;

	assign u_val = 64'(mu_prod >> FRAC_BITS);

	always_comb begin
		dneg = 1'b0;
		if (!mu_item.xneg) begin
			dm = mu_item.s + u_val;
		end else if (mu_item.s >= u_val) begin
			dm = mu_item.s - u_val;
		end else begin
			dm = u_val - mu_item.s;
			dneg = 1'b1;
		end
		unique case (mu_item.act)
			ACT_SILU: begin
				fa = mu_item.xm;
				fb = mu_item.s;
				fneg = mu_item.xneg;
			end
			ACT_SILU_GRAD: begin
				fa = mu_item.gm;
				fb = dm;
				fneg = mu_item.gneg ^ dneg;
			end
			ACT_SIGMOID: begin
				fa = ONE_FIX;
				fb = mu_item.s;
				fneg = 1'b0;
			end
			default: begin
				fa = mu_item.gm;
				fb = mu_item.t;
				fneg = mu_item.gneg;
			end
		endcase
	end

	item_t f_item;
	logic f_v_s1;
	item_t f_item_s1;
	logic [31:0] fa_s1;
	logic [63:0] fb_s1;

	always_comb begin
		f_item = mu_item;
		f_item.neg = fneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_s1 <= 1'b0;
		end else if (en) begin
			f_v_s1 <= mu_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_item_s1 <= f_item;
			fa_s1 <= fa;
			fb_s1 <= fb;
		end
	end

	logic fo_v;
	item_t fo_item;
	logic [127:0] fo_prod;

	ssa_mul64 u_mul_f (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(f_v_s1), .in_item(f_item_s1), .a({32'd0, fa_s1}), .b(fb_s1),
		.out_v(fo_v), .out_item(fo_item), .prod(fo_prod)
	);

	logic [65:0] mag;
	logic [31:0] res;
	logic res_sat;
	logic [31:0] xraw;
	logic [31:0] graw;

	assign mag = 66'((fo_prod + HALF_ULP) >> 62);
	assign xraw = fo_item.xneg ? 32'd0 - fo_item.xm : fo_item.xm;
	assign graw = fo_item.gneg ? 32'd0 - fo_item.gm : fo_item.gm;

	always_comb begin
		res_sat = 1'b0;
		if (fo_item.big) begin
			if (fo_item.xneg) begin
				res = 32'd0;
			end else begin
				unique case (fo_item.act)
					ACT_SILU: res = xraw;
					ACT_SILU_GRAD: res = graw;
					ACT_SIGMOID: res = ONE_FIX;
					default: res = 32'd0;
				endcase
			end
		end else if (fo_item.neg) begin
			if (mag > 66'h8000_0000) begin
				res = 32'h8000_0000;
				res_sat = 1'b1;
			end else begin
				res = 32'd0 - mag[31:0];
			end
		end else begin
			if (mag > 66'h7FFF_FFFF) begin
				res = 32'h7FFF_FFFF;
				res_sat = 1'b1;
			end else begin
				res = mag[31:0];
			end
		end
	end

	logic push;
	logic [31:0] out_val_q;
	logic out_sat_q;
	logic out_last_q;
	logic [31:0] skid_val_q;
	logic skid_sat_q;
	logic skid_last_q;

	assign push = fo_v && en;
	assign take = out_v_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_val_q <= skid_val_q;
				out_sat_q <= skid_sat_q;
				out_last_q <= skid_last_q;
			end
		end else if (push) begin
			if (out_v_q && !take) begin
				skid_val_q <= res;
				skid_sat_q <= res_sat;
				skid_last_q <= fo_item.last;
			end else begin
				out_val_q <= res;
				out_sat_q <= res_sat;
				out_last_q <= fo_item.last;
			end
		end
	end

	assign result_valid = out_v_q;
	assign result_value = out_val_q;
	assign saturated = out_sat_q;
	assign last_out = out_last_q;

endmodule

### test/ssa_activation_checker.sv
// Checker that predicts every activation result and compares it with the block's output.
`timescale 1ns / 100ps

module ssa_activation_checker (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic stall,
	input logic [1:0] action,
	input logic signed [31:0] x_value,
	input logic signed [31:0] grad_value,
	input logic last_in,
	input logic result_valid,
	input logic result_stall,
	input logic signed [31:0] result_value,
	input logic saturated,
	input logic last_out,
	output int fail_count,
	output int pending_count
);
	import ssa_pkg::*;

	localparam int FRAC = 16;

	typedef struct packed {
		logic [31:0] value;
		logic sat;
		logic last;
	} act_result_t;

	act_result_t expected_results[$];

	function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
			input int sh, input bit rnd);
		logic [127:0] p;
		p = a * b;
		if (rnd)
			p = p + (128'd1 << (sh - 1));
		p = p >> sh;
		if (p[127:64] != 0)
			return 64'hFFFF_FFFF_FFFF_FFFF;
		return p[63:0];
	endfunction

	function automatic logic [63:0] q62_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		q = 0;
		rem = num;
		if (rem >= den) begin
			q = 1;
			rem = rem - den;
		end
		for (int i = 0; i < 62; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] exp_neg(input logic [63:0] a56);
		logic [63:0] k;
		logic [63:0] r;
		logic [63:0] e;
		k = a56 / LN2_Q56;
		r = (a56 - k * LN2_Q56) << 6;
		e = QONE;
		for (int i = N_TERMS; i >= 1; i--)
			e = QONE - mul_shr(r, e, 62, 0) / i;
		if (k >= 63)
			return 0;
		return e >> k;
	endfunction

	function automatic act_result_t sign_and_clip(input logic [63:0] mag, input bit neg);
		act_result_t res;
		res = '0;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				mag = 64'h8000_0000;
				res.sat = 1'b1;
			end
			res.value = 32'(64'h1_0000_0000 - mag);
		end else begin
			if (mag > 64'h7FFF_FFFF) begin
				mag = 64'h7FFF_FFFF;
				res.sat = 1'b1;
			end
			res.value = mag[31:0];
		end
		return res;
	endfunction

	function automatic act_result_t predict_activation(input logic [1:0] act,
			input logic [31:0] xr, input logic [31:0] gr, input logic lst);
		act_result_t res;
		logic xneg;
		logic gneg;
		logic [63:0] xm;
		logic [63:0] gm;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] s;
		logic [63:0] oms;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] dm;
		logic dneg;
		xneg = xr[31];
		gneg = gr[31];
		xm = xneg ? 64'h1_0000_0000 - xr : {32'd0, xr};
		gm = gneg ? 64'h1_0000_0000 - gr : {32'd0, gr};
		res = '0;
		if (xm > (64'd80 << FRAC)) begin
			if (!xneg) begin
				case (act)
					ACT_SILU: res.value = xr;
					ACT_SILU_GRAD: res.value = gr;
					ACT_SIGMOID: res.value = 32'd1 << FRAC;
					default: res.value = 0;
				endcase
			end
		end else begin
			e = exp_neg(xm << (56 - FRAC));
			den = QONE + e;
			hi = q62_div(QONE, den);
			lo = q62_div(e, den);
			s = xneg ? lo : hi;
			oms = xneg ? hi : lo;
			t = mul_shr(s, oms, 62, 0);
			case (act)
				ACT_SILU: res = sign_and_clip(mul_shr(xm, s, 62, 1), xneg);
				ACT_SILU_GRAD: begin
					u = mul_shr(xm, t, FRAC, 0);
					dneg = 0;
					if (!xneg)
						dm = s + u;
					else if (s >= u)
						dm = s - u;
					else begin
						dm = u - s;
						dneg = 1;
					end
					res = sign_and_clip(mul_shr(gm, dm, 62, 1), gneg != dneg);
				end
				ACT_SIGMOID: res = sign_and_clip((s + (64'd1 << (61 - FRAC))) >> (62 - FRAC), 0);
				default: res = sign_and_clip(mul_shr(gm, t, 62, 1), gneg);
			endcase
		end
		res.last = lst;
		return res;
	endfunction

	assign pending_count = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		act_result_t exp_res;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (valid && !stall)
				expected_results.push_back(predict_activation(action, x_value, grad_value,
					last_in));
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word value=%h", $time, result_value);
					fail_count <= fail_count + 1;
				end else begin
					exp_res = expected_results.pop_front();
					if (exp_res.value !== result_value || exp_res.sat !== saturated
							|| exp_res.last !== last_out) begin
						$display("%0t: mismatch expected value=%h sat=%b last=%b actual value=%h sat=%b last=%b",
							$time, exp_res.value, exp_res.sat, exp_res.last,
							result_value, saturated, last_out);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### test/tb_sigmoid_silu_activation_unit.sv
// Testbench top that drives elements into the activation unit and reports the verdict.
`timescale 1ns / 100ps

module tb_sigmoid_silu_activation_unit;
	import ssa_pkg::*;

	localparam int N_RANDOM = 800;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic valid = 0;
	logic stall;
	logic [1:0] action = ACT_SILU;
	logic signed [31:0] x_value = 0;
	logic signed [31:0] grad_value = 0;
	logic last_in = 0;
	logic result_valid;
	logic result_stall = 0;
	logic signed [31:0] result_value;
	logic saturated;
	logic last_out;
	int fail_count;
	int pending_count;
	int cycle_count = 0;
	bit calm_phase = 0;

	always #6 clk = ~clk;

	sigmoid_silu_activation_unit i_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .action(action),
		.x_value(x_value), .grad_value(grad_value), .last_in(last_in),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_value(result_value), .saturated(saturated), .last_out(last_out)
	);

	ssa_activation_checker i_checker (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .action(action),
		.x_value(x_value), .grad_value(grad_value), .last_in(last_in),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_value(result_value), .saturated(saturated), .last_out(last_out),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		result_stall <= !calm_phase && ($urandom_range(99) < 15);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] random_x();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(32'h50_0000)) - 32'sh28_0000);
			2: return 32'($signed($urandom_range(32'hA0_0000)) - 32'sh50_0000);
			3: return 32'($signed($urandom_range(32'h1_0000)) - 32'sh8000);
			4: return $urandom_range(1) ? 32'h50_0000 + $urandom_range(2) - 1
				: 32'hFFB0_0000 + $urandom_range(2) - 1;
			default: return 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
		endcase
	endfunction

	task automatic send_element(input logic [1:0] act, input logic [31:0] xv,
			input logic [31:0] gv, input logic lst);
		while (!calm_phase && $urandom_range(99) < 15) begin
			valid <= 0;
			@(posedge clk);
		end
		valid <= 1;
		action <= act;
		x_value <= xv;
		grad_value <= gv;
		last_in <= lst;
		do
			@(posedge clk);
		while (stall);
	endtask

	initial begin
		logic [31:0] edge_x [10];
		edge_x = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h50_0000, 32'hFFB0_0000,
			32'h50_0001, 32'hFFAF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1_0000};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (edge_x[i])
			for (int a = 0; a < 4; a++)
				if (i < 6 || a % 2 == 1)
					send_element(a[1:0], edge_x[i],
						(i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'(i % 2));
		for (int n = 0; n < N_RANDOM; n++) begin
			calm_phase = (n >= 300 && n < 450);
			send_element(2'($urandom_range(3)), random_x(),
				$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h4_0000),
				1'($urandom_range(1)));
		end
		valid <= 0;
		calm_phase = 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
